>>> design/ows_pkg.sv
// ----------------------------------------------------------------------------
// ows_pkg: shared types and constants for the OHLC / Welford statistics unit
// Field widths, count limit and iteration counts of the serial arithmetic.
// ----------------------------------------------------------------------------
`default_nettype none

package ows_pkg;

    // window sample count width and limit
    localparam int COUNT_BITS = 16;
    localparam int PRICE_W    = 32;
    localparam int STD_W      = 31;
    localparam int SCNT_W     = 16;
    localparam int ACC_W      = 64;
    localparam int ROOT_W     = ACC_W / 2;

    // serial divider iteration counts
    localparam int DIV_ITER_W     = 7;
    localparam int MEAN_DIV_ITERS = PRICE_W;
    localparam int VAR_DIV_ITERS  = ACC_W;

    typedef logic signed [PRICE_W-1:0] price_t;
    typedef logic [COUNT_BITS-1:0]     count_t;
    typedef logic [ACC_W-1:0]          acc_t;
    typedef logic [ROOT_W-1:0]         root_t;
    typedef logic [STD_W-1:0]          std_t;
    typedef logic [SCNT_W-1:0]         scnt_t;
    typedef logic [DIV_ITER_W-1:0]     iter_t;

    localparam count_t CNT_LIMIT = '1;
    localparam std_t   STD_MAX   = '1;

endpackage

`default_nettype wire

>>> design/ows_div_unit.sv
// ----------------------------------------------------------------------------
// ows_div_unit: radix-2 restoring divider
// Unsigned dividend by window count, one quotient bit per cycle. The caller
// picks the number of steps; the quotient collects in the low bits.
// ----------------------------------------------------------------------------
`default_nettype none

module ows_div_unit (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire ows_pkg::iter_t  iters,
    input  wire ows_pkg::acc_t   dividend,
    input  wire ows_pkg::count_t divisor,
    output logic               done,
    output ows_pkg::acc_t      quotient
);
    import ows_pkg::*;

    logic   busy_reg;
    logic   done_reg;
    iter_t  cnt_reg;
    count_t dvsr_reg;
    count_t rem_reg;
    acc_t   quo_reg;

    logic [COUNT_BITS:0] shifted;
    logic [COUNT_BITS:0] trial;
    logic                fits;

    // one trial subtraction per cycle
    assign shifted = {rem_reg, quo_reg[ACC_W-1]};
    assign trial   = shifted - {1'b0, dvsr_reg};
    assign fits    = (shifted >= {1'b0, dvsr_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            dvsr_reg <= '0;
            rem_reg  <= '0;
            quo_reg  <= '0;
        end
        else
        begin
            // pulse after the final step
            done_reg <= busy_reg && !start && (cnt_reg == iter_t'(1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= iters;
                dvsr_reg <= divisor;
                rem_reg  <= '0;
                quo_reg  <= dividend;
            end
            else if (busy_reg)
            begin
                rem_reg <= fits ? trial[COUNT_BITS-1:0] : shifted[COUNT_BITS-1:0];
                quo_reg <= {quo_reg[ACC_W-2:0], fits};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == iter_t'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

>>> design/ows_isqrt_unit.sv
// ----------------------------------------------------------------------------
// ows_isqrt_unit: bit-serial integer square root
// Digit-by-digit root of a 64-bit value, one result bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ows_isqrt_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire ows_pkg::acc_t radicand,
    output logic             done,
    output ows_pkg::root_t   root
);
    import ows_pkg::*;

    localparam acc_t BIT_INIT = acc_t'(1) << (ACC_W - 2);

    logic busy_reg;
    logic done_reg;
    acc_t val_reg;
    acc_t res_reg;
    acc_t bit_reg;

    acc_t trial;
    logic fits;

    // compare remainder against res + bit
    assign trial = res_reg + bit_reg;
    assign fits  = (val_reg >= trial);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            val_reg  <= '0;
            res_reg  <= '0;
            bit_reg  <= '0;
        end
        else
        begin
            // pulse after the step with the lowest bit
            done_reg <= busy_reg && !start && bit_reg[0];
            if (start)
            begin
                busy_reg <= 1'b1;
                val_reg  <= radicand;
                res_reg  <= '0;
                bit_reg  <= BIT_INIT;
            end
            else if (busy_reg)
            begin
                if (fits)
                begin
                    val_reg <= val_reg - trial;
                    res_reg <= (res_reg >> 1) + bit_reg;
                end
                else
                begin
                    res_reg <= res_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
                if (bit_reg[0])
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    assign done = done_reg;
    assign root = res_reg[ROOT_W-1:0];

endmodule

`default_nettype wire

>>> design/ohlc_welford_window_stats_unit.sv
// ----------------------------------------------------------------------------
// ohlc_welford_window_stats_unit: OHLC and Welford mean / std-dev per window
// Per sample: a sample that opens the window or is dropped needs no arithmetic;
//   any other runs a 32-step serial divide for the mean and a shift-add multiply
//   for the deviation, whose length follows the bit length of |p - new mean|.
// Closing a window of more than one sample adds a 64-step divide and a 32-step square root.
// One sample in flight at a time. Reset clears all window state to zero.
// ----------------------------------------------------------------------------
`default_nettype none

module ohlc_welford_window_stats_unit (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire ows_pkg::price_t  price,
    input  wire logic             last,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output ows_pkg::price_t       open_value,
    output ows_pkg::price_t       high_value,
    output ows_pkg::price_t       low_value,
    output ows_pkg::price_t       close_value,
    output ows_pkg::price_t       mean_value,
    output ows_pkg::std_t         std_dev,
    output ows_pkg::scnt_t        sample_count,
    output logic                  overflowed
);
    import ows_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FOLD,
        S_DIV,
        S_MUL,
        S_ACC,
        S_FIN,
        S_VDIV,
        S_SQRT,
        S_EMIT
    } state_t;

    state_t state_reg;

    // window state
    price_t open_reg, high_reg, low_reg, close_reg, mean_reg;
    acc_t   sq_sum_reg;
    count_t count_reg;
    logic   ovf_reg;

    // per-sample working registers
    price_t              price_reg;
    logic                last_reg;
    logic                dneg_reg;
    logic [PRICE_W-1:0]  dmag_reg;
    acc_t                mcand_reg;
    logic [PRICE_W-1:0]  mplier_reg;
    acc_t                prod_reg;
    std_t                sd_reg;

    // output beat registers
    logic   out_valid_reg;
    price_t open_out_reg, high_out_reg, low_out_reg, close_out_reg, mean_out_reg;
    std_t   std_out_reg;
    scnt_t  scnt_out_reg;
    logic   ovf_out_reg;

    // arithmetic units
    logic   div_start, div_done;
    iter_t  div_iters;
    acc_t   div_dividend, div_quotient;
    count_t div_divisor;
    logic   sqrt_start, sqrt_done;
    root_t  sqrt_root;

    // deviation from the old mean
    logic [PRICE_W:0]   d_diff;
    logic [PRICE_W:0]   d_abs;
    // new mean and deviation from it
    logic [PRICE_W:0]   q_ext;
    logic [PRICE_W:0]   new_mean;
    logic [PRICE_W:0]   e_diff;
    logic [PRICE_W:0]   e_abs;
    logic [ACC_W:0]     sq_total;
    logic               emit_fire;

    assign d_diff = {price_reg[PRICE_W-1], price_reg} - {mean_reg[PRICE_W-1], mean_reg};
    assign d_abs  = d_diff[PRICE_W] ? (~d_diff + 1'b1) : d_diff;

    assign q_ext    = {1'b0, div_quotient[PRICE_W-1:0]};
    assign new_mean = dneg_reg ? ({mean_reg[PRICE_W-1], mean_reg} - q_ext)
                               : ({mean_reg[PRICE_W-1], mean_reg} + q_ext);
    assign e_diff   = {price_reg[PRICE_W-1], price_reg} - new_mean;
    assign e_abs    = e_diff[PRICE_W] ? (~e_diff + 1'b1) : e_diff;

    assign sq_total = {1'b0, sq_sum_reg} + {1'b0, prod_reg};

    // divider shared by the mean update and the variance at window close
    assign div_start    = (state_reg == S_FOLD && count_reg != CNT_LIMIT && count_reg != '0)
                       || (state_reg == S_FIN && count_reg > count_t'(1));
    assign div_iters    = (state_reg == S_FOLD) ? iter_t'(MEAN_DIV_ITERS)
                                                : iter_t'(VAR_DIV_ITERS);
    assign div_dividend = (state_reg == S_FOLD) ? {d_abs[PRICE_W-1:0], {(ACC_W-PRICE_W){1'b0}}}
                                                : sq_sum_reg;
    assign div_divisor  = (state_reg == S_FOLD) ? count_reg + 1'b1 : count_reg;

    assign sqrt_start = (state_reg == S_VDIV) && div_done;

    assign emit_fire = (state_reg == S_EMIT) && (!out_valid_reg || out_ready);

    ows_div_unit u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .iters    (div_iters),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    ows_isqrt_unit u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (div_quotient),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    // sequencer, window state and output beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            open_reg      <= '0;
            high_reg      <= '0;
            low_reg       <= '0;
            close_reg     <= '0;
            mean_reg      <= '0;
            sq_sum_reg    <= '0;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            price_reg     <= '0;
            last_reg      <= 1'b0;
            dneg_reg      <= 1'b0;
            dmag_reg      <= '0;
            mcand_reg     <= '0;
            mplier_reg    <= '0;
            prod_reg      <= '0;
            sd_reg        <= '0;
            out_valid_reg <= 1'b0;
            open_out_reg  <= '0;
            high_out_reg  <= '0;
            low_out_reg   <= '0;
            close_out_reg <= '0;
            mean_out_reg  <= '0;
            std_out_reg   <= '0;
            scnt_out_reg  <= '0;
            ovf_out_reg   <= 1'b0;
        end
        else
        begin
            // beat taken and nothing new to load
            if (out_valid_reg && out_ready && !emit_fire)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        price_reg <= price;
                        last_reg  <= last;
                        state_reg <= S_FOLD;
                    end
                end

                S_FOLD:
                begin
                    if (count_reg == CNT_LIMIT)
                    begin
                        // window full: drop the sample
                        ovf_reg   <= 1'b1;
                        state_reg <= last_reg ? S_FIN : S_IDLE;
                    end
                    else if (count_reg == '0)
                    begin
                        // first sample opens the window
                        open_reg   <= price_reg;
                        high_reg   <= price_reg;
                        low_reg    <= price_reg;
                        close_reg  <= price_reg;
                        mean_reg   <= price_reg;
                        sq_sum_reg <= '0;
                        count_reg  <= count_t'(1);
                        state_reg  <= last_reg ? S_FIN : S_IDLE;
                    end
                    else
                    begin
                        if (price_reg > high_reg)
                        begin
                            high_reg <= price_reg;
                        end
                        if (price_reg < low_reg)
                        begin
                            low_reg <= price_reg;
                        end
                        close_reg <= price_reg;
                        dneg_reg  <= d_diff[PRICE_W];
                        dmag_reg  <= d_abs[PRICE_W-1:0];
                        state_reg <= S_DIV;
                    end
                end

                S_DIV:
                begin
                    if (div_done)
                    begin
                        mean_reg   <= new_mean[PRICE_W-1:0];
                        mcand_reg  <= acc_t'(dmag_reg);
                        mplier_reg <= e_abs[PRICE_W-1:0];
                        prod_reg   <= '0;
                        count_reg  <= count_reg + 1'b1;
                        state_reg  <= S_MUL;
                    end
                end

                S_MUL:
                begin
                    // shift-add, one multiplier bit per cycle
                    if (mplier_reg == '0)
                    begin
                        state_reg <= S_ACC;
                    end
                    else
                    begin
                        if (mplier_reg[0])
                        begin
                            prod_reg <= prod_reg + mcand_reg;
                        end
                        mcand_reg  <= mcand_reg << 1;
                        mplier_reg <= mplier_reg >> 1;
                    end
                end

                S_ACC:
                begin
                    // saturating accumulate of the product of the two deviations
                    sq_sum_reg <= sq_total[ACC_W] ? '1 : sq_total[ACC_W-1:0];
                    state_reg  <= last_reg ? S_FIN : S_IDLE;
                end

                S_FIN:
                begin
                    if (count_reg > count_t'(1))
                    begin
                        state_reg <= S_VDIV;
                    end
                    else
                    begin
                        sd_reg    <= '0;
                        state_reg <= S_EMIT;
                    end
                end

                S_VDIV:
                begin
                    if (div_done)
                    begin
                        state_reg <= S_SQRT;
                    end
                end

                S_SQRT:
                begin
                    if (sqrt_done)
                    begin
                        sd_reg    <= sqrt_root[ROOT_W-1] ? STD_MAX : sqrt_root[STD_W-1:0];
                        state_reg <= S_EMIT;
                    end
                end

                S_EMIT:
                begin
                    if (emit_fire)
                    begin
                        out_valid_reg <= 1'b1;
                        open_out_reg  <= open_reg;
                        high_out_reg  <= high_reg;
                        low_out_reg   <= low_reg;
                        close_out_reg <= close_reg;
                        mean_out_reg  <= mean_reg;
                        std_out_reg   <= sd_reg;
                        scnt_out_reg  <= scnt_t'(count_reg);
                        ovf_out_reg   <= ovf_reg;
                        // start a fresh window
                        open_reg      <= '0;
                        high_reg      <= '0;
                        low_reg       <= '0;
                        close_reg     <= '0;
                        mean_reg      <= '0;
                        sq_sum_reg    <= '0;
                        count_reg     <= '0;
                        ovf_reg       <= 1'b0;
                        state_reg     <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_ready     = (state_reg == S_IDLE);
    assign out_valid    = out_valid_reg;
    assign open_value   = open_out_reg;
    assign high_value   = high_out_reg;
    assign low_value    = low_out_reg;
    assign close_value  = close_out_reg;
    assign mean_value   = mean_out_reg;
    assign std_dev      = std_out_reg;
    assign sample_count = scnt_out_reg;
    assign overflowed   = ovf_out_reg;

    // divider only reports back while the sequencer waits for it
    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIV || state_reg == S_VDIV))
        else $error("divider done outside a divide wait");

    // root only reports back while the sequencer waits for it
    a_sqrt_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        sqrt_done |-> (state_reg == S_SQRT))
        else $error("square root done outside its wait");

    // an emitted window always holds at least one sample
    a_emit_count: assert property (@(posedge clk) disable iff (!rst_n)
        emit_fire |=> (out_valid && sample_count != '0))
        else $error("window emitted with zero samples");

    // window state is cleared after emitting
    a_emit_clear: assert property (@(posedge clk) disable iff (!rst_n)
        emit_fire |=> (count_reg == '0 && !ovf_reg && sq_sum_reg == '0))
        else $error("window not cleared after emit");

    // count never runs past the limit once a sample is folded
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV && div_done) |-> (count_reg != CNT_LIMIT))
        else $error("mean update with count at limit");

endmodule

`default_nettype wire

>>> dv/ohlc_welford_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ohlc_welford_checker: window statistics scoreboard for the OHLC / Welford unit
// Watches both channels. Every input beat is folded into a local window model.
// A beat that carries last queues the expected OHLC, mean, std-dev, count and
// overflow flag. Each result beat is compared field by field against the
// oldest queued window.
// ----------------------------------------------------------------------------

module ohlc_welford_checker (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic            in_ready,
    input  ows_pkg::price_t price,
    input  logic            last,
    input  logic            out_valid,
    input  logic            out_ready,
    input  ows_pkg::price_t open_value,
    input  ows_pkg::price_t high_value,
    input  ows_pkg::price_t low_value,
    input  ows_pkg::price_t close_value,
    input  ows_pkg::price_t mean_value,
    input  ows_pkg::std_t   std_dev,
    input  ows_pkg::scnt_t  sample_count,
    input  logic            overflowed,
    output int              error_count,
    output int              windows_pending,
    output int              windows_closed,
    output int              samples_seen
);

    typedef struct packed {
        ows_pkg::price_t open_v;
        ows_pkg::price_t high_v;
        ows_pkg::price_t low_v;
        ows_pkg::price_t close_v;
        ows_pkg::price_t mean_v;
        ows_pkg::std_t   std_v;
        ows_pkg::scnt_t  cnt_v;
        logic            ovf_v;
    } window_stats_t;

    // samples past this count are dropped and flag the window
    localparam logic [63:0] FOLD_CAP = (64'd1 << ows_pkg::COUNT_BITS) - 64'd1;

    window_stats_t expected_windows[$];
    window_stats_t want;

    // running window state
    ows_pkg::price_t win_open  = '0;
    ows_pkg::price_t win_high  = '0;
    ows_pkg::price_t win_low   = '0;
    ows_pkg::price_t win_close = '0;
    ows_pkg::price_t win_mean  = '0;
    logic [63:0]     win_sq    = '0;
    logic [63:0]     win_cnt   = '0;
    logic            win_ovf   = 1'b0;

    int mismatches = 0;
    int pending    = 0;
    int closed     = 0;
    int taken      = 0;

    assign error_count     = mismatches;
    assign windows_pending = pending;
    assign windows_closed  = closed;
    assign samples_seen    = taken;

    function automatic logic [63:0] magnitude(longint v);
        return (v < 0) ? -v : v;
    endfunction

    // fold one sample; on the closing sample queue the window and start over
    function automatic void fold_sample(ows_pkg::price_t p, logic closes);
        longint        pl;
        longint        dev;
        longint        new_mean;
        logic [63:0]   prod;
        logic [63:0]   var_q;
        logic [63:0]   root;
        logic [63:0]   trial;
        window_stats_t res;
        pl = p;
        if (win_cnt >= FOLD_CAP) begin
            win_ovf = 1'b1;
        end else begin
            if (win_cnt == 0) begin
                win_open  = p;
                win_high  = p;
                win_low   = p;
                win_close = p;
                win_mean  = p;
                win_sq    = '0;
            end else begin
                if (p > win_high)
                    win_high = p;
                if (p < win_low)
                    win_low = p;
                win_close = p;
                // Welford step, division truncates toward zero
                dev      = pl - longint'(win_mean);
                new_mean = longint'(win_mean) + dev / $signed(win_cnt + 64'd1);
                prod     = magnitude(dev) * magnitude(pl - new_mean);
                win_mean = ows_pkg::price_t'(new_mean);
                if (prod > ~win_sq)
                    win_sq = '1;
                else
                    win_sq = win_sq + prod;
            end
            win_cnt = win_cnt + 64'd1;
        end

        if (closes) begin
            root = '0;
            if (win_cnt > 1) begin
                var_q = win_sq / win_cnt;
                // bitwise root search, most significant bit first
                for (int b = 31; b >= 0; b--) begin
                    trial = root | (64'd1 << b);
                    if (trial * trial <= var_q)
                        root = trial;
                end
                if (root > 64'(ows_pkg::STD_MAX))
                    root = 64'(ows_pkg::STD_MAX);
            end
            res.open_v  = win_open;
            res.high_v  = win_high;
            res.low_v   = win_low;
            res.close_v = win_close;
            res.mean_v  = win_mean;
            res.std_v   = root[ows_pkg::STD_W-1:0];
            res.cnt_v   = win_cnt[ows_pkg::SCNT_W-1:0];
            res.ovf_v   = win_ovf;
            expected_windows.insert(expected_windows.size(), res);
            win_open  = '0;
            win_high  = '0;
            win_low   = '0;
            win_close = '0;
            win_mean  = '0;
            win_sq    = '0;
            win_cnt   = '0;
            win_ovf   = 1'b0;
        end
    endfunction

    task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
        if (act_v !== exp_v) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
            mismatches++;
        end
    endtask

    // result beats are retired before input beats of the same edge
    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid && out_ready) begin
                if (expected_windows.size() == 0) begin
                    $error("result beat with no window pending");
                    mismatches++;
                end else begin
                    want = expected_windows.pop_front();
                    check_field("open_value",   want.open_v,  open_value);
                    check_field("high_value",   want.high_v,  high_value);
                    check_field("low_value",    want.low_v,   low_value);
                    check_field("close_value",  want.close_v, close_value);
                    check_field("mean_value",   want.mean_v,  mean_value);
                    check_field("std_dev",      want.std_v,   std_dev);
                    check_field("sample_count", want.cnt_v,   sample_count);
                    check_field("overflowed",   want.ovf_v,   overflowed);
                    closed++;
                end
            end
            if (in_valid && in_ready) begin
                fold_sample(price, last);
                taken++;
            end
            pending = expected_windows.size();
        end
    end

endmodule

>>> dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: stimulus and verdict for the OHLC / Welford window statistics unit
// Directed extreme, small, flat and price-like windows, random windows with random
// idling on both channels, one long output stall, then a gap-free closing part.
// Checking is done by ohlc_welford_checker.
// ----------------------------------------------------------------------------

module tb;

    localparam ows_pkg::price_t P_MAX = 32'sh7FFF_FFFF;
    localparam ows_pkg::price_t P_MIN = 32'sh8000_0000;

    localparam int     RANDOM_ITEMS = 450;
    localparam int     TAIL_ITEMS   = 80;
    localparam int     LONG_HOLD    = 1500;
    localparam int     DRAIN_CYCLES = 300;
    localparam longint CYCLE_LIMIT  = 20_000_000;

    logic            clk       = 1'b0;
    logic            rst_n     = 1'b0;
    logic            in_valid  = 1'b0;
    ows_pkg::price_t price     = '0;
    logic            last      = 1'b0;
    logic            out_ready = 1'b0;

    logic            in_ready;
    logic            out_valid;
    ows_pkg::price_t open_value;
    ows_pkg::price_t high_value;
    ows_pkg::price_t low_value;
    ows_pkg::price_t close_value;
    ows_pkg::price_t mean_value;
    ows_pkg::std_t   std_dev;
    ows_pkg::scnt_t  sample_count;
    logic            overflowed;

    int error_count;
    int windows_pending;
    int windows_closed;
    int samples_seen;

    // idle controls for the sender and receiver processes, set by the main sequence
    bit tx_gaps   = 1'b0;
    bit rx_gaps   = 1'b0;
    bit hold_long = 1'b0;

    longint cycle_count = 0;

    ohlc_welford_window_stats_unit u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .price        (price),
        .last         (last),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .open_value   (open_value),
        .high_value   (high_value),
        .low_value    (low_value),
        .close_value  (close_value),
        .mean_value   (mean_value),
        .std_dev      (std_dev),
        .sample_count (sample_count),
        .overflowed   (overflowed)
    );

    ohlc_welford_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .price           (price),
        .last            (last),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .open_value      (open_value),
        .high_value      (high_value),
        .low_value       (low_value),
        .close_value     (close_value),
        .mean_value      (mean_value),
        .std_dev         (std_dev),
        .sample_count    (sample_count),
        .overflowed      (overflowed),
        .error_count     (error_count),
        .windows_pending (windows_pending),
        .windows_closed  (windows_closed),
        .samples_seen    (samples_seen)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // hard stop
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // result side: random stall bursts, plus one long hold on request
    initial
    begin
        int stall_left;
        stall_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
                stall_left--;
            else if (hold_long)
            begin
                stall_left = LONG_HOLD;
                hold_long  = 1'b0;
            end
            else if (rx_gaps && $urandom_range(0, 4) == 0)
                stall_left = $urandom_range(1, 10);
            out_ready <= (stall_left == 0);
        end
    end

    // mix of full range, small signed, near extremes and price-like values
    function automatic ows_pkg::price_t pick_price();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(0, 5))
            0, 1:    return r;
            2:       return {{24{r[7]}}, r[7:0]};
            3:       return P_MAX - r[1:0];
            4:       return P_MIN + r[1:0];
            default: return 32'sh0064_0000 + {{15{r[16]}}, r[16:0]};
        endcase
    endfunction

    // one input beat, entered and left at a falling edge
    task automatic push_sample(ows_pkg::price_t p, logic closes);
        int gap;
        if (tx_gaps && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 10);
            in_valid <= 1'b0;
            price    <= $urandom;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        price    <= p;
        last     <= closes;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // random windows, mostly short with the odd longer one
    task automatic run_windows(int n_items);
        int sent;
        int len;
        sent = 0;
        while (sent < n_items)
        begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
            for (int k = 0; k < len; k++)
                push_sample(pick_price(), k == len - 1);
            sent += len;
        end
    endtask

    initial
    begin
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // single-sample windows at zero and both extremes
        push_sample('0, 1'b1);
        push_sample(P_MAX, 1'b1);
        push_sample(P_MIN, 1'b1);
        // widest two-sample spread
        push_sample(P_MAX, 1'b0);
        push_sample(P_MIN, 1'b1);
        // alternating extremes drive the squared sum into saturation
        for (int i = 0; i < 6; i++)
            push_sample(i[0] ? P_MAX : P_MIN, i == 5);
        // small mixed-sign values, mean steps truncate toward zero
        push_sample(32'sd3, 1'b0);
        push_sample(-32'sd4, 1'b0);
        push_sample(32'sd7, 1'b0);
        push_sample(-32'sd1, 1'b1);
        // flat window: count above one with zero deviation
        push_sample(32'sh0010_0000, 1'b0);
        push_sample(32'sh0010_0000, 1'b0);
        push_sample(32'sh0010_0000, 1'b1);
        // price-like Q16.16 window with a new high then a new low
        push_sample(32'sh0064_8000, 1'b0);
        push_sample(32'sh0065_0000, 1'b0);
        push_sample(32'sh0063_4000, 1'b0);
        push_sample(32'sh0064_0000, 1'b1);

        // random windows, idling switched on and off per part, long output hold from the third part
        tx_gaps = 1'b1;
        rx_gaps = 1'b1;
        run_windows(RANDOM_ITEMS / 4);
        tx_gaps = 1'b0;
        rx_gaps = 1'b0;
        run_windows(RANDOM_ITEMS / 8);
        tx_gaps   = 1'b1;
        rx_gaps   = 1'b1;
        hold_long = 1'b1;
        run_windows(RANDOM_ITEMS / 4);
        tx_gaps = 1'b0;
        run_windows(RANDOM_ITEMS / 8);
        tx_gaps = 1'b1;
        run_windows(RANDOM_ITEMS / 4);

        // closing part without idling
        tx_gaps = 1'b0;
        rx_gaps = 1'b0;
        run_windows(TAIL_ITEMS);

        in_valid <= 1'b0;
        while (windows_pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Checked %0d windows from %0d samples: extreme and flat windows,", windows_closed,
                 samples_seen);
        $display("random windows with idling, a %0d-cycle output hold and a gap-free tail.",
                 LONG_HOLD);
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
